// ===== hdl/bar_graph_page_renderer_macros.svh =====
// Assertion helpers shared by the renderer modules.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BAR_GRAPH_PAGE_RENDERER_MACROS_SVH
`define BAR_GRAPH_PAGE_RENDERER_MACROS_SVH

// Generic clocked check.
`define BGPR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BGPR_IMPLY(label, ante, cons, msg) \
  `BGPR_CHECK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BGPR_NEXT(label, ante, cons, msg) \
  `BGPR_CHECK(label, (ante) |=> (cons), msg)

`endif

// ===== hdl/bgpr_pkg.sv =====
package bgpr_pkg;

  localparam int MaxColumns = 84;
  localparam int Pages      = 5;

  localparam int ColW     = $clog2(MaxColumns + 1);  // count 0..MaxColumns
  localparam int AddrW    = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  localparam int PageW    = $clog2(Pages + 1);       // page 0..Pages
  localparam int HeightW  = 7;
  localparam int SampleW  = 8;
  localparam int ByteW    = 8;

  localparam logic [ByteW-1:0] PageCmd   = 8'h40;
  localparam logic [ByteW-1:0] ColCmd    = 8'h80;
  localparam logic [ByteW-1:0] PageMask  = 8'h07;
  localparam logic [ByteW-1:0] ByteFull  = 8'hFF;
  localparam logic [ByteW-1:0] ByteEmpty = 8'h00;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [HeightW-1:0] data;
  } wr_t;

  typedef struct packed {
    logic              vld;      // the accepted item yields a byte
    logic              rd;       // byte comes from the column store
    logic [AddrW-1:0]  addr;
    logic [ByteW-1:0]  data_byte;
    logic              is_data;
    logic              eof;
    logic [PageW-1:0]  page;
  } emit_t;

  // Pixel byte of one column on one page: n bits set from bit 7 down.
  function automatic logic [ByteW-1:0] bar_byte(logic [HeightW-1:0] h,
                                                logic [PageW-1:0] page);
    logic [8:0]        off;
    logic signed [9:0] n;
    logic [15:0]       fill;
    off  = 9'(Pages - 1) - 9'(page);
    off  = off << 3;
    n    = $signed({3'b000, h}) - $signed({1'b0, off});
    fill = 16'hFF00 >> n[2:0];
    if (n < 0) begin
      return ByteEmpty;
    end else if (n >= 10'sd8) begin
      return ByteFull;
    end
    return fill[ByteW-1:0];
  endfunction

endpackage

// ===== hdl/bgpr_if.sv =====
interface bgpr_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [bgpr_pkg::SampleW-1:0]    sample;
  logic                            final_sample;

  modport source (output valid, func, sample, final_sample, input ready);
  modport sink   (input valid, func, sample, final_sample, output ready);
endinterface

interface bgpr_out_if;
  logic                          valid;
  logic                          ready;
  logic [bgpr_pkg::ByteW-1:0]    out_byte;
  logic                          is_data;
  logic                          end_of_frame;

  modport source (output valid, out_byte, is_data, end_of_frame, input ready);
  modport sink   (input valid, out_byte, is_data, end_of_frame, output ready);
endinterface

// ===== hdl/bar_graph_page_renderer.sv =====
// Bar graph page renderer.
// in_i carries load items (func 0) and tick items (func 1). A load stores
// sample/2 as the next column height; the load marked final_sample starts a
// render. Each tick during a render returns one byte on out_o: per page the
// page command, the column command, then one pixel byte per stored column.
// end_of_frame marks the last byte, after which the store is empty again.
// Loads during a render, and ticks while idle, give no byte.
// Timing: for a load or a command tick, its byte, if any, is in the output
// register the next cycle. A pixel tick first reads the column store, a
// synchronous RAM with a registered read, and in_i is not ready during that
// read. Loads and commands flow at one item per cycle while the receiver
// keeps up; after a pixel tick no new item is taken until its read is done.
// When the receiver stalls, the byte waits in the output register and in_i
// stays not ready, loads included, until the receiver takes that byte.
// Reset clears all counters and the render state; the column store keeps
// its contents, and entries are only read after a load wrote them.
`include "bar_graph_page_renderer_macros.svh"

module bar_graph_page_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgpr_in_if.sink     in_i,
  bgpr_out_if.source  out_o
);

  bgpr_pkg::wr_t                  wr;
  bgpr_pkg::emit_t                emit;
  logic [bgpr_pkg::HeightW-1:0]   rd_data;
  logic                           accept;
  logic                           in_ready;

  logic                           pend_q;
  logic                           pend_eof_q;
  logic [bgpr_pkg::PageW-1:0]     pend_page_q;
  logic                           out_vld_q;
  logic [bgpr_pkg::ByteW-1:0]     out_byte_q;
  logic                           is_data_q;
  logic                           eof_q;

  assign in_ready   = !pend_q && (!out_vld_q || out_o.ready);
  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  bgpr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (in_i.func),
    .sample_i       (in_i.sample),
    .final_sample_i (in_i.final_sample),
    .wr_o           (wr),
    .emit_o         (emit)
  );

  bgpr_col_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (emit.rd),
    .rd_addr_i (emit.addr),
    .rd_data_o (rd_data)
  );

  // pixel item waiting for its column read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= emit.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.rd) begin
      pend_eof_q  <= emit.eof;
      pend_page_q <= emit.page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      priority if (pend_q) begin
        out_vld_q <= 1'b1;
      end else if (emit.vld && !emit.rd) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (pend_q) begin
      out_byte_q <= bgpr_pkg::bar_byte(rd_data, pend_page_q);
      is_data_q  <= 1'b1;
      eof_q      <= pend_eof_q;
    end else if (emit.vld && !emit.rd) begin
      out_byte_q <= emit.data_byte;
      is_data_q  <= emit.is_data;
      eof_q      <= emit.eof;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.is_data      = is_data_q;
  assign out_o.end_of_frame = eof_q;

  `BGPR_IMPLY(a_pend_slot_free, pend_q, !out_vld_q,
              "output register busy while a column read is pending")
  `BGPR_NEXT(a_pend_fills_out, pend_q, out_vld_q,
             "pending pixel byte did not reach the output register")
  `BGPR_IMPLY(a_eof_is_pixel, out_vld_q && eof_q, is_data_q,
              "end of frame marked on a command byte")

endmodule

// ===== hdl/bgpr_col_store.sv =====
module bgpr_col_store (
  input  logic                           clk_i,
  input  bgpr_pkg::wr_t                  wr_i,
  input  logic                           rd_en_i,
  input  logic [bgpr_pkg::AddrW-1:0]     rd_addr_i,
  output logic [bgpr_pkg::HeightW-1:0]   rd_data_o
);

  logic [bgpr_pkg::HeightW-1:0] mem_q [bgpr_pkg::MaxColumns];
  logic [bgpr_pkg::HeightW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/bgpr_ctrl.sv =====
`include "bar_graph_page_renderer_macros.svh"

module bgpr_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           func_i,
  input  logic [bgpr_pkg::SampleW-1:0]   sample_i,
  input  logic                           final_sample_i,
  output bgpr_pkg::wr_t                  wr_o,
  output bgpr_pkg::emit_t                emit_o
);

  typedef enum logic [1:0] {
    PhPageCmd,
    PhColCmd,
    PhData
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic                         rendering_q, rendering_d;
  logic [bgpr_pkg::ColW-1:0]    col_cnt_q, col_cnt_d;
  logic [bgpr_pkg::ColW-1:0]    col_idx_q, col_idx_d;
  logic [bgpr_pkg::PageW-1:0]   page_q, page_d;
  logic [bgpr_pkg::ColW-1:0]    col_nxt;
  logic [bgpr_pkg::PageW-1:0]   page_nxt;
  logic                         is_load, is_tick;

  assign is_load  = accept_i && (func_i == bgpr_pkg::FuncLoad) && !rendering_q;
  assign is_tick  = accept_i && (func_i == bgpr_pkg::FuncTick) && rendering_q;
  assign col_nxt  = col_idx_q + 1'b1;
  assign page_nxt = page_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    rendering_d = rendering_q;
    col_cnt_d   = col_cnt_q;
    col_idx_d   = col_idx_q;
    page_d      = page_q;

    wr_o.en   = 1'b0;
    wr_o.addr = col_cnt_q[bgpr_pkg::AddrW-1:0];
    wr_o.data = sample_i[bgpr_pkg::SampleW-1:1];

    emit_o.vld       = 1'b0;
    emit_o.rd        = 1'b0;
    emit_o.addr      = col_idx_q[bgpr_pkg::AddrW-1:0];
    emit_o.data_byte = bgpr_pkg::ColCmd;
    emit_o.is_data   = 1'b0;
    emit_o.eof       = 1'b0;
    emit_o.page      = page_q;

    if (is_load) begin
      // samples past capacity are dropped, the final mark still counts
      if (col_cnt_q < bgpr_pkg::ColW'(bgpr_pkg::MaxColumns)) begin
        wr_o.en   = 1'b1;
        col_cnt_d = col_cnt_q + 1'b1;
      end
      if (final_sample_i) begin
        rendering_d = 1'b1;
        phase_d     = PhPageCmd;
        col_idx_d   = '0;
        page_d      = '0;
      end
    end else if (is_tick) begin
      emit_o.vld = 1'b1;
      unique case (phase_q)
        PhPageCmd: begin
          emit_o.data_byte = bgpr_pkg::PageCmd
                           | (bgpr_pkg::ByteW'(page_q) & bgpr_pkg::PageMask);
          phase_d = PhColCmd;
        end
        PhColCmd: begin
          emit_o.data_byte = bgpr_pkg::ColCmd;
          phase_d = PhData;
        end
        default: begin
          emit_o.rd      = 1'b1;
          emit_o.is_data = 1'b1;
          col_idx_d      = col_nxt;
          if (col_nxt >= col_cnt_q) begin
            col_idx_d = '0;
            phase_d   = PhPageCmd;
            page_d    = page_nxt;
            if (page_nxt >= bgpr_pkg::PageW'(bgpr_pkg::Pages)) begin
              emit_o.eof  = 1'b1;
              page_d      = '0;
              rendering_d = 1'b0;
              col_cnt_d   = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhPageCmd;
      rendering_q <= 1'b0;
      col_cnt_q   <= '0;
      col_idx_q   <= '0;
      page_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      rendering_q <= rendering_d;
      col_cnt_q   <= col_cnt_d;
      col_idx_q   <= col_idx_d;
      page_q      <= page_d;
    end
  end

  `BGPR_IMPLY(a_render_nonempty, rendering_q, col_cnt_q != '0,
              "render running with an empty column store")
  `BGPR_IMPLY(a_idx_in_range, rendering_q, col_idx_q < col_cnt_q,
              "column index beyond stored columns")
  `BGPR_NEXT(a_eof_ends_render, emit_o.eof, !rendering_q && col_cnt_q == '0,
             "render did not close after the last byte")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int CycleLimit = 1_000_000;
  localparam int ItemTarget = 1000;

  typedef struct packed {
    logic [bgpr_pkg::ByteW-1:0] out_byte;
    logic                       is_data;
    logic                       eof;
  } byte_res_t;

  typedef enum logic [1:0] {PhPageCmd, PhColCmd, PhPixels} phase_e;

  typedef struct {
    logic                         func;
    logic [bgpr_pkg::SampleW-1:0] sample;
    logic                         fin;
    bit                           typed;
    bit                           has_res;
    byte_res_t                    res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bgpr_in_if  in_if ();
  bgpr_out_if out_if ();

  bar_graph_page_renderer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [bgpr_pkg::HeightW-1:0] col_h [bgpr_pkg::MaxColumns];
  logic [bgpr_pkg::ColW-1:0]    col_cnt;
  logic [bgpr_pkg::ColW-1:0]    col_idx;
  logic [bgpr_pkg::PageW-1:0]   pg;
  phase_e                       phase;
  bit                           rendering;

  byte_res_t   pending_bytes[$];
  stim_row_t   plan[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_used   = 0;
  int unsigned src_calm     = 0;
  bit          hold_done    = 0;

  function automatic logic [bgpr_pkg::ByteW-1:0] column_fill(
      logic [bgpr_pkg::HeightW-1:0] h, logic [bgpr_pkg::PageW-1:0] page);
    int n;
    n = int'(h) - (bgpr_pkg::Pages - 1 - int'(page)) * 8;
    if (n < 0) return bgpr_pkg::ByteEmpty;
    if (n >= 8) return bgpr_pkg::ByteFull;
    return 8'(16'hFF00 >> n);
  endfunction

  task automatic predict_byte(input logic f, input logic [bgpr_pkg::SampleW-1:0] s,
                              input logic fin, output bit yields, output byte_res_t res,
                              output bit used);
    yields = 0;
    res    = '0;
    used   = 0;
    if (f == bgpr_pkg::FuncLoad) begin
      if (rendering) return;
      used = 1;
      if (col_cnt < bgpr_pkg::MaxColumns) begin
        col_h[col_cnt] = s[bgpr_pkg::SampleW-1:1];
        col_cnt++;
      end
      // final mark starts the render even when the sample was dropped
      if (fin) begin
        rendering = 1;
        pg        = '0;
        phase     = PhPageCmd;
        col_idx   = '0;
      end
      return;
    end
    if (!rendering) return;
    used   = 1;
    yields = 1;
    unique case (phase)
      PhPageCmd: begin
        res.out_byte = bgpr_pkg::PageCmd
                     | (bgpr_pkg::ByteW'(pg) & bgpr_pkg::PageMask);
        phase        = PhColCmd;
      end
      PhColCmd: begin
        res.out_byte = bgpr_pkg::ColCmd;
        phase        = PhPixels;
      end
      default: begin
        res.out_byte = column_fill(col_h[col_idx], pg);
        res.is_data  = 1'b1;
        col_idx++;
        if (col_idx >= col_cnt) begin
          col_idx = '0;
          phase   = PhPageCmd;
          pg++;
          if (pg >= bgpr_pkg::Pages) begin
            res.eof   = 1'b1;
            pg        = '0;
            rendering = 0;
            col_cnt   = '0;
          end
        end
      end
    endcase
  endtask

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bgpr_pkg::SampleW-1:0] rand_sample();
    if ($urandom_range(0, 3) == 0) return bgpr_pkg::SampleW'($urandom_range(0, 100));
    return bgpr_pkg::SampleW'($urandom_range(0, 255));
  endfunction

  task automatic add_row(input logic f, input logic [bgpr_pkg::SampleW-1:0] s,
                         input logic fin, input bit typed, input bit has_res,
                         input byte_res_t res);
    stim_row_t row;
    row.func    = f;
    row.sample  = s;
    row.fin     = fin;
    row.typed   = typed;
    row.has_res = has_res;
    row.res     = res;
    plan.push_back(row);
  endtask

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic f, input logic [bgpr_pkg::SampleW-1:0] s,
                           input logic fin, input bit typed, input bit t_has,
                           input byte_res_t t_res);
    int unsigned gap;
    bit          yields;
    bit          used;
    byte_res_t   res;
    gap = pick_gap(src_calm);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.sample       <= s;
    in_if.final_sample <= fin;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_byte(f, s, fin, yields, res, used);
    if (typed) begin
      yields = t_has;
      res    = t_res;
    end
    if (yields) pending_bytes.push_back(res);
    if (used) items_used++;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: cycle limit reached, %0d bytes outstanding", $time, pending_bytes.size());
    $display("** bar_graph_page_renderer: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin : check_bytes
    byte_res_t got;
    byte_res_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = {out_if.out_byte, out_if.is_data, out_if.end_of_frame};
      results_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected item: byte %h is_data %b eof %b", $time,
                 got.out_byte, got.is_data, got.eof);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          $display({"%0t: mismatch: expected byte %h is_data %b eof %b,",
                    " got byte %h is_data %b eof %b"},
                   $time, want.out_byte, want.is_data, want.eof,
                   got.out_byte, got.is_data, got.eof);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin : sink_side
    int unsigned run;
    int unsigned stall;
    int unsigned calm;
    calm = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1;
        stall     = 400;
      end else begin
        stall = pick_gap(calm);
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : source_side
    int unsigned len;
    int unsigned cut;
    int unsigned ticks;
    int unsigned series;
    bit          broken;
    in_if.valid        <= 1'b0;
    in_if.func         <= bgpr_pkg::FuncLoad;
    in_if.sample       <= '0;
    in_if.final_sample <= 1'b0;

    foreach (col_h[i]) col_h[i] = '0;
    col_cnt   = '0;
    col_idx   = '0;
    pg        = '0;
    phase     = PhPageCmd;
    rendering = 0;

    // directed: idle tick, two-column frame (h=10 and h=127), load during render
    add_row(bgpr_pkg::FuncTick, 8'hFF, 1'b1, 1, 0, '0);
    add_row(bgpr_pkg::FuncLoad, 8'h15, 1'b0, 0, 0, '0);
    add_row(bgpr_pkg::FuncLoad, 8'hFF, 1'b1, 0, 0, '0);
    add_row(bgpr_pkg::FuncLoad, 8'h00, 1'b1, 1, 0, '0);
    for (int p = 0; p < bgpr_pkg::Pages; p++) begin
      add_row(bgpr_pkg::FuncTick, 8'h00, 1'b0, 1, 1,
              {bgpr_pkg::PageCmd | (bgpr_pkg::ByteW'(p) & bgpr_pkg::PageMask), 1'b0, 1'b0});
      add_row(bgpr_pkg::FuncTick, 8'hFF, 1'b1, 1, 1, {bgpr_pkg::ColCmd, 1'b0, 1'b0});
      add_row(bgpr_pkg::FuncTick, rand_sample(), 1'($urandom_range(0, 1)), 0, 0, '0);
      add_row(bgpr_pkg::FuncTick, 8'h00, 1'b0, 1, 1,
              {bgpr_pkg::ByteFull, 1'b1, 1'(p == bgpr_pkg::Pages - 1)});
    end
    add_row(bgpr_pkg::FuncTick, 8'hA5, 1'b1, 1, 0, '0);

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (plan[i])
      send_item(plan[i].func, plan[i].sample, plan[i].fin, plan[i].typed,
                plan[i].has_res, plan[i].res);

    series = 0;
    while (items_used < ItemTarget) begin
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 3))
          send_item(bgpr_pkg::FuncTick, rand_sample(), 1'($urandom_range(0, 1)), 0, 0, '0);

      // first series overflows the store, second fills it exactly
      if (series == 0) len = bgpr_pkg::MaxColumns + 2;
      else if (series == 1) len = bgpr_pkg::MaxColumns;
      else begin
        cut = $urandom_range(0, 99);
        if (cut < 70) len = $urandom_range(1, 8);
        else if (cut < 90) len = $urandom_range(9, 40);
        else if (cut < 96) len = bgpr_pkg::MaxColumns;
        else len = $urandom_range(bgpr_pkg::MaxColumns + 1, bgpr_pkg::MaxColumns + 4);
      end

      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 24) == 0)
          send_item(bgpr_pkg::FuncTick, rand_sample(), 1'($urandom_range(0, 1)), 0, 0, '0);
        send_item(bgpr_pkg::FuncLoad, rand_sample(), 1'(i == len - 1), 0, 0, '0);
      end

      // a broken sequence leaves the render unfinished; the next series runs into it
      broken = ($urandom_range(0, 19) == 0);
      cut    = $urandom_range(1, 10);
      ticks  = 0;
      while (rendering && !(broken && ticks >= cut)) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(bgpr_pkg::FuncLoad, rand_sample(), 1'($urandom_range(0, 1)), 0, 0, '0);
        end else begin
          send_item(bgpr_pkg::FuncTick, rand_sample(), 1'($urandom_range(0, 1)), 0, 0, '0);
          ticks++;
        end
      end
      series++;
    end
    // finish any render left open so every byte is drained
    while (rendering)
      send_item(bgpr_pkg::FuncTick, rand_sample(), 1'($urandom_range(0, 1)), 0, 0, '0);
    in_if.valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** bar_graph_page_renderer: PASSED **");
    end else begin
      $display("** bar_graph_page_renderer: FAILED **");
    end
    $finish;
  end

endmodule
